@@ sv/search_result_cache_top_defines.svh @@
// Assertion helpers for the search result cache.
`ifndef SEARCH_RESULT_CACHE_TOP_DEFINES_SVH
`define SEARCH_RESULT_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRCH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/srch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srch_pkg;

    localparam int CMD_W      = 2;
    localparam int KEY_W      = 64;
    localparam int SCORE_W    = 16;
    localparam int DEPTH_W    = 7;
    localparam int PLY_W      = 7;
    localparam int BOUND_W    = 2;
    localparam int MOVE_W     = 32;
    localparam int GEN_W      = 8;
    localparam int THR_W      = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [THR_W-1:0]     MATE_THR_RESET = 15'd31000;
    localparam logic [GEN_W-1:0]     GEN_MAX        = 8'd255;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MATE   = 1'b0;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PROBE   = 2'd0,
        CMD_STORE   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                      valid;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic [GEN_W-1:0]          gen;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/srch_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface srch_item_if import srch_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [KEY_W-1:0]          position_key;
    logic signed [SCORE_W-1:0] alpha_bound;
    logic signed [SCORE_W-1:0] beta_bound;
    logic [DEPTH_W-1:0]        search_depth;
    logic [PLY_W-1:0]          ply_from_root;
    logic signed [SCORE_W-1:0] score_in;
    logic [BOUND_W-1:0]        bound_kind;
    logic [MOVE_W-1:0]         move_in;

    modport source (
        output valid, command, position_key, alpha_bound, beta_bound,
               search_depth, ply_from_root, score_in, bound_kind, move_in,
        input  ready
    );
    modport sink (
        input  valid, command, position_key, alpha_bound, beta_bound,
               search_depth, ply_from_root, score_in, bound_kind, move_in,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/srch_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface srch_result_if import srch_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      key_hit;
    logic                      score_usable;
    logic signed [SCORE_W-1:0] score_out;
    logic [MOVE_W-1:0]         stored_move;
    logic                      replaced;

    modport source (
        output valid, key_hit, score_usable, score_out, stored_move, replaced,
        input  ready
    );
    modport sink (
        input  valid, key_hit, score_usable, score_out, stored_move, replaced,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/search_result_cache_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Handshake      Beat
// i_item     in   valid/ready    command, key, window, depth, ply, score, bound, move
// o_result   out  valid/ready    key_hit, score_usable, score_out, stored_move, replaced
// cfg (APB)  in   psel/penable   mate_threshold at byte address 0 (pready tied high)
//
// Steps: the synchronous table read on accept; in execute, the read-modify-write
//   of the entry and the load of the result register; no new beat is taken meanwhile.
// Clear: the result beat is issued, then a sweep writes every entry
//   invalid, one per cycle, with i_item.ready low.
// Reset: the same sweep runs after reset, before the first beat is taken;
//   configuration writes are taken throughout.
// Stalls: a full result register with o_result.ready low holds the beat
//   in the execute cycle; the table write waits with it.
// TABLE_ENTRIES must be a power of two: the entry index is the low key bits.

`include "search_result_cache_top_defines.svh"

module search_result_cache_top import srch_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    srch_item_if.sink                  i_item,
    srch_result_if.source              o_result
);

    localparam int              IDX_W    = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [THR_W-1:0]     r_mate_thr;
    logic [CFG_IDX_W-1:0] w_cfg_idx;
    logic                 w_cfg_we;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign w_cfg_we  = psel && penable && pwrite && pready && (w_cfg_idx == CFG_IDX_MATE);
    assign prdata    = (w_cfg_idx == CFG_IDX_MATE) ?
                       CFG_DATA_W'(r_mate_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_thr <= MATE_THR_RESET;
        end else if (w_cfg_we) begin
            r_mate_thr <= pwdata[THR_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    t_state           r_state, n_state;
    logic [GEN_W-1:0] r_gen, n_gen;
    logic [IDX_W-1:0] r_sweep_idx;
    logic             r_out_valid;

    logic w_in_fire;
    logic w_out_free;
    logic w_issue;
    logic w_sweep_done;

    // Captured beat
    t_cmd                      r_cmd;
    logic [KEY_W-1:0]          r_key;
    logic signed [SCORE_W-1:0] r_alpha;
    logic signed [SCORE_W-1:0] r_beta;
    logic [DEPTH_W-1:0]        r_depth;
    logic [PLY_W-1:0]          r_ply;
    logic signed [SCORE_W-1:0] r_score_in;
    logic [BOUND_W-1:0]        r_bound;
    logic [MOVE_W-1:0]         r_move;

    // Table: one synchronous memory, whole entry per word
    t_entry           mem_table [TABLE_ENTRIES];
    t_entry           r_rd;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_addr;
    t_entry           w_mem_wdata;

    assign w_in_fire    = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_sweep_done = (r_sweep_idx == LAST_IDX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: if (w_sweep_done) n_state = ST_IDLE;
            ST_IDLE:  if (w_in_fire) n_state = ST_EXEC;
            ST_EXEC: begin
                if (w_out_free) begin
                    n_state = (r_cmd == CMD_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            default:  n_state = ST_SWEEP;
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = 1'b0;
        w_issue      = 1'b0;
        unique case (r_state)
            ST_SWEEP: ;
            ST_IDLE:  i_item.ready = 1'b1;
            ST_EXEC:  w_issue = w_out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_gen       <= '0;
            r_sweep_idx <= '0;
        end else begin
            r_state <= n_state;
            r_gen   <= n_gen;
            if (r_state == ST_SWEEP) begin
                r_sweep_idx <= w_sweep_done ? '0 : r_sweep_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd      <= t_cmd'(i_item.command);
            r_key      <= i_item.position_key;
            r_alpha    <= i_item.alpha_bound;
            r_beta     <= i_item.beta_bound;
            r_depth    <= i_item.search_depth;
            r_ply      <= i_item.ply_from_root;
            r_score_in <= i_item.score_in;
            r_bound    <= i_item.bound_kind;
            r_move     <= i_item.move_in;
        end
    end

    // ---------------------------------------------------------------
    // Memory: read on accept, written in execute or sweep
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rd <= mem_table[i_item.position_key[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_table[w_mem_addr] <= w_mem_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Execute: probe scoring and store replacement
    // ---------------------------------------------------------------
    logic signed [SCORE_W:0] w_ply17, w_thr17, w_nthr17;
    logic signed [SCORE_W:0] w_ent17, w_probe_s, w_alpha17, w_beta17;
    logic signed [SCORE_W:0] w_in17, w_store_sum;
    logic signed [SCORE_W-1:0] w_store_sat;
    logic w_hit, w_depth_ok, w_replace;
    logic w_res_usable;
    logic signed [SCORE_W-1:0] w_res_score;

    assign w_ply17   = $signed({{(SCORE_W+1-PLY_W){1'b0}}, r_ply});
    assign w_thr17   = $signed({{(SCORE_W+1-THR_W){1'b0}}, r_mate_thr});
    assign w_nthr17  = -w_thr17;
    assign w_ent17   = $signed({r_rd.score[SCORE_W-1], r_rd.score});
    assign w_alpha17 = $signed({r_alpha[SCORE_W-1], r_alpha});
    assign w_beta17  = $signed({r_beta[SCORE_W-1], r_beta});
    assign w_in17    = $signed({r_score_in[SCORE_W-1], r_score_in});

    assign w_hit      = r_rd.valid && (r_rd.key == r_key);
    assign w_depth_ok = (r_rd.depth >= r_depth);

    // mate scores are stored relative to the node, reported relative to root
    always_comb begin
        priority if (w_ent17 > w_thr17) begin
            w_probe_s = w_ent17 - w_ply17;
        end else if (w_ent17 < w_nthr17) begin
            w_probe_s = w_ent17 + w_ply17;
        end else begin
            w_probe_s = w_ent17;
        end
    end

    always_comb begin
        w_res_usable = 1'b0;
        w_res_score  = '0;
        if (w_hit && w_depth_ok) begin
            priority if (r_rd.bound == BOUND_EXACT) begin
                w_res_usable = 1'b1;
                w_res_score  = w_probe_s[SCORE_W-1:0];
            end else if (r_rd.bound == BOUND_UPPER && w_probe_s <= w_alpha17) begin
                w_res_usable = 1'b1;
                w_res_score  = r_alpha;
            end else if (r_rd.bound == BOUND_LOWER && w_probe_s >= w_beta17) begin
                w_res_usable = 1'b1;
                w_res_score  = r_beta;
            end else begin
                w_res_usable = 1'b0;
            end
        end
    end

    assign w_replace = !r_rd.valid || (r_rd.key == r_key) ||
                       (r_rd.gen != r_gen) || (r_rd.depth <= r_depth);

    always_comb begin
        priority if (w_in17 > w_thr17) begin
            w_store_sum = w_in17 + w_ply17;
        end else if (w_in17 < w_nthr17) begin
            w_store_sum = w_in17 - w_ply17;
        end else begin
            w_store_sum = w_in17;
        end
    end

    // saturate back to 16 bits
    always_comb begin
        priority if (w_store_sum[SCORE_W] != w_store_sum[SCORE_W-1]) begin
            w_store_sat = w_store_sum[SCORE_W] ?
                          $signed({1'b1, {(SCORE_W-1){1'b0}}}) :
                          $signed({1'b0, {(SCORE_W-1){1'b1}}});
        end else begin
            w_store_sat = w_store_sum[SCORE_W-1:0];
        end
    end

    // write port: sweep clears, execute stores
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = r_key[IDX_W-1:0];
        w_mem_wdata = '0;
        if (r_state == ST_SWEEP) begin
            w_mem_we   = 1'b1;
            w_mem_addr = r_sweep_idx;
        end else if (w_issue && r_cmd == CMD_STORE && w_replace) begin
            w_mem_we          = 1'b1;
            w_mem_wdata.valid = 1'b1;
            w_mem_wdata.key   = r_key;
            w_mem_wdata.depth = r_depth;
            w_mem_wdata.bound = r_bound;
            w_mem_wdata.score = w_store_sat;
            w_mem_wdata.move  = r_move;
            w_mem_wdata.gen   = r_gen;
        end
    end

    always_comb begin
        n_gen = r_gen;
        if (w_issue) begin
            unique case (r_cmd)
                CMD_ADVANCE: n_gen = (r_gen == GEN_MAX) ? '0 : r_gen + 1'b1;
                CMD_CLEAR:   n_gen = '0;
                CMD_PROBE,
                CMD_STORE:   n_gen = r_gen;
                default:     n_gen = r_gen;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                      r_out_hit;
    logic                      r_out_usable;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [MOVE_W-1:0]         r_out_move;
    logic                      r_out_repl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_issue) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out_hit    <= (r_cmd == CMD_PROBE) && w_hit;
            r_out_usable <= (r_cmd == CMD_PROBE) && w_res_usable;
            r_out_score  <= (r_cmd == CMD_PROBE) ? w_res_score : '0;
            r_out_move   <= ((r_cmd == CMD_PROBE) && w_hit) ? r_rd.move : '0;
            r_out_repl   <= (r_cmd == CMD_STORE) && w_replace;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.key_hit      = r_out_hit;
    assign o_result.score_usable = r_out_usable;
    assign o_result.score_out    = r_out_score;
    assign o_result.stored_move  = r_out_move;
    assign o_result.replaced     = r_out_repl;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SRCH_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_in_fire, r_state == ST_EXEC,
        "accepted beat did not move to execute")
    `SRCH_ASSERT_NOW(a_usable_needs_hit, i_clk, i_rst_n,
        o_result.valid && o_result.score_usable, o_result.key_hit,
        "usable score without key hit")
    `SRCH_ASSERT_NOW(a_replace_not_probe, i_clk, i_rst_n,
        o_result.valid && o_result.replaced,
        !o_result.key_hit && !o_result.score_usable && o_result.stored_move == '0,
        "store result carries probe fields")
    `SRCH_ASSERT_NOW(a_write_when_busy, i_clk, i_rst_n, w_mem_we,
        r_state == ST_SWEEP || (r_state == ST_EXEC && w_issue),
        "table written outside sweep or issue")

endmodule

`default_nettype wire
